### sv/assert_macros.svh
// assertion macros shared by the light area normalizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CLAN_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("clan check failed");
`define CLAN_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clan implication failed");
`else
`define CLAN_CHECK(lbl, prop)
`define CLAN_IMPLY(lbl, ante, cons)
`endif
`endif

### sv/clan_pkg.sv
// types, constants and step functions of the light area normalizer
`timescale 1ns / 1ps
`default_nettype none
package clan_pkg;
	localparam int FRAC_BITS = 16;
	localparam int SCL_W = 64 - FRAC_BITS;
	localparam int SUM_W = SCL_W + 1;
	localparam int AREA_W = 63;
	localparam int SQ_LAT = 16;
	localparam int DIV_LAT = 33;
	localparam int MUL_LAT = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYL_LENGTH = 1'd1;

	localparam logic [63:0] PI_Q32 = 64'd13493037705;
	localparam logic [63:0] RND_HALF = 64'd1 << (31 - FRAC_BITS);
	localparam logic [63:0] PI_Q = (PI_Q32 + RND_HALF) >> (32 - FRAC_BITS);
	localparam logic [63:0] TWO_PI_Q = (2 * PI_Q32 + RND_HALF) >> (32 - FRAC_BITS);
	localparam logic [63:0] FOUR_PI_Q = (4 * PI_Q32 + RND_HALF) >> (32 - FRAC_BITS);
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
	localparam logic [63:0] NEAR_Q = (ONE_Q + 64'd9999) / 64'd10000;
	localparam logic [63:0] FOUR_Q = 4 * ONE_Q;
	localparam logic [63:0] TEN_Q = 10 * ONE_Q;
	localparam logic [AREA_W-1:0] AREA_CAP = {1'b1, {(AREA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic [31:0] color_r;
		logic [31:0] color_g;
		logic [31:0] color_b;
	} item_t;

	typedef struct packed {
		logic [31:0] out_r;
		logic [31:0] out_g;
		logic [31:0] out_b;
		logic saturated;
	} result_t;

	// everything an item carries down the pipe
	typedef struct packed {
		logic [2:0][31:0] rgb;
		logic [SCL_W-1:0] sx;
		logic [SCL_W-1:0] sy;
		logic [SCL_W-1:0] sz;
		logic [SCL_W-1:0] d;
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] sxz;
		logic zero;
		logic near;
		logic azero;
		logic [FRAC_BITS-1:0] h;
		logic [FRAC_BITS:0] f;
		logic [AREA_W-1:0] cap2;
		logic [AREA_W-1:0] narea;
		logic [AREA_W-1:0] pis;
		logic [AREA_W-1:0] area;
	} side_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [63:0] v;
	} sq_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] q;
		logic [62:0] den;
		logic sat;
	} dv_t;

	function automatic logic [31:0] mag32(logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	// one root digit from the next two radicand bits
	function automatic sq_t sq_step(sq_t a);
		sq_t o;
		logic [35:0] rn;
		logic [35:0] tr;
		rn = {a.rem[33:0], a.v[63:62]};
		tr = {2'b00, a.root, 2'b01};
		o.v = {a.v[61:0], 2'b00};
		if (rn >= tr) begin
			o.rem = rn - tr;
			o.root = {a.root[30:0], 1'b1};
		end else begin
			o.rem = rn;
			o.root = {a.root[30:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit at weight sh
	function automatic dv_t div_step(dv_t a, int sh);
		dv_t o;
		logic [95:0] dsh;
		dsh = {33'b0, a.den} << sh;
		o = a;
		if ({32'b0, a.rem} >= dsh) begin
			o.rem = a.rem - dsh[63:0];
			o.q = a.q | (32'd1 << sh);
		end
		return o;
	endfunction
endpackage
`default_nettype wire

### sv/clan_isqrt.sv
// three-lane pipelined integer square root, two root bits per stage
`timescale 1ns / 1ps
`default_nettype none
module clan_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  clan_pkg::side_t in_side,
	input  logic [2:0][63:0] rad,
	output logic out_vld,
	output clan_pkg::side_t out_side,
	output logic [2:0][31:0] root
);
	import clan_pkg::*;

	logic [SQ_LAT-1:0] vld_s;
	side_t side_s [SQ_LAT];
	sq_t [2:0] st_c [SQ_LAT];
	sq_t [2:0] st_s [SQ_LAT];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			st_c[0][l] = sq_step(sq_step(sq_t'{rem: '0, root: '0, v: rad[l]}));
		end
		for (int k = 1; k < SQ_LAT; k++) begin
			for (int l = 0; l < 3; l++) begin
				st_c[k][l] = sq_step(sq_step(st_s[k-1][l]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SQ_LAT-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int k = 1; k < SQ_LAT; k++) begin
			side_s[k] <= side_s[k-1];
		end
		st_s <= st_c;
	end

	assign out_vld = vld_s[SQ_LAT-1];
	assign out_side = side_s[SQ_LAT-1];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			root[l] = st_s[SQ_LAT-1][l].root;
		end
	end
endmodule
`default_nettype wire

### sv/clan_div.sv
// three-lane pipelined divider, 32-bit quotient with overflow flag
`timescale 1ns / 1ps
`default_nettype none
module clan_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  clan_pkg::side_t in_side,
	input  logic [2:0][63:0] num,
	input  logic [2:0][62:0] den,
	output logic out_vld,
	output clan_pkg::side_t out_side,
	output logic [2:0][31:0] quot,
	output logic [2:0] sat
);
	import clan_pkg::*;

	logic [DIV_LAT-1:0] vld_s;
	side_t side_s [DIV_LAT];
	dv_t [2:0] st_c [DIV_LAT];
	dv_t [2:0] st_s [DIV_LAT];

	always_comb begin
		// first stage only checks that the quotient fits in 32 bits
		for (int l = 0; l < 3; l++) begin
			st_c[0][l] = dv_t'{rem: num[l], q: '0, den: den[l],
				sat: ({den[l], 32'b0} <= {31'b0, num[l]})};
		end
		for (int k = 1; k < DIV_LAT; k++) begin
			for (int l = 0; l < 3; l++) begin
				st_c[k][l] = div_step(st_s[k-1][l], DIV_LAT - 1 - k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DIV_LAT-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int k = 1; k < DIV_LAT; k++) begin
			side_s[k] <= side_s[k-1];
		end
		st_s <= st_c;
	end

	assign out_vld = vld_s[DIV_LAT-1];
	assign out_side = side_s[DIV_LAT-1];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			quot[l] = st_s[DIV_LAT-1][l].q;
			sat[l] = st_s[DIV_LAT-1][l].sat;
		end
	end
endmodule
`default_nettype wire

### sv/clan_mulq.sv
// pipelined fixed-point multiply with clamp to the area cap
`timescale 1ns / 1ps
`default_nettype none
module clan_mulq (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  clan_pkg::side_t in_side,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic out_vld,
	output clan_pkg::side_t out_side,
	output logic [clan_pkg::AREA_W-1:0] p
);
	import clan_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	side_t side_s1, side_s2, side_s3;
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [127:0] prod_s2;
	logic [AREA_W-1:0] p_s3;
	logic [111:0] shf;

	assign shf = prod_s2[127:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		p00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
		p01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
		p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
		p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		prod_s2 <= {p11_s1, 64'b0} + {32'b0, p01_s1, 32'b0} + {32'b0, p10_s1, 32'b0}
			+ {64'b0, p00_s1};
		p_s3 <= (shf > {49'b0, AREA_CAP}) ? AREA_CAP : shf[AREA_W-1:0];
	end

	assign out_vld = vld_s3;
	assign out_side = side_s3;
	assign p = p_s3;
endmodule
`default_nettype wire

### sv/cylinder_light_area_normalize.sv
// top level of the cylinder light color normalizer
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Takes one light (3x3 transform and RGB color) per clock and returns its
// color divided by area/(4*pi) of the scaled elliptic cylinder, one result
// per cycle on done. The pipeline is made of the three 33-stage dividers
// (axis ratio, Ramanujan correction, color), the two 16-stage square roots
// and the seven 3-stage multipliers, plus the glue registers between them.
// busy stays low: the pipeline never stalls and the receiver cannot hold
// results off. The user must write radius and cyl_length through the cfg
// channel only while no light is in flight; the block does not enforce it.
module cylinder_light_area_normalize (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  clan_pkg::item_t item,
	output logic done,
	output clan_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [clan_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import clan_pkg::*;

	localparam int LAT = 2 + SQ_LAT + 2 + 5 * MUL_LAT + DIV_LAT + 1 + SQ_LAT + DIV_LAT + 1
		+ 2 * MUL_LAT + 1 + 1 + DIV_LAT + 1;

	logic [31:0] radius_q, cyl_length_q;

	logic [2:0][2:0][31:0] mag_c;
	side_t side_c1, side_c4, side_c5, side_c7, side_c8, side_c9;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s7, vld_s8, vld_s9, vld_s10;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s7, side_s8, side_s9;
	logic [2:0][2:0][63:0] sq_s1;
	logic [2:0][63:0] len2_s2;
	logic [2:0][63:0] scl_s3;
	logic [2:0][63:0] num_s9;
	result_t result_s10;

	logic vld_u1, vld_u2, vld_d1, vld_d2, vld_d3;
	side_t side_u1, side_u2, side_d1, side_d2, side_d3;
	logic [2:0][31:0] len_u1, root_u2;
	logic [2:0][63:0] rad_u2, num_d1, num_d2;
	logic [2:0][62:0] den_d1, den_d2, den_d3;
	logic [2:0][31:0] quot_d1, quot_d2, quot_d3;
	logic [2:0] sat_d1, sat_d2, sat_d3;

	logic vld_m1, vld_m2, vld_m3, vld_m4, vld_m5, vld_m6, vld_m7;
	side_t side_m1, side_m2, side_m3, side_m4, side_m5, side_m6, side_m7;
	side_t side_m3i, side_m5i, side_d1i;
	logic [AREA_W-1:0] p_m1, p_m2, p_m3, p_m4, p_m5, p_m6, p_m7;

	logic [FRAC_BITS-1:0] q5;
	logic [2*FRAC_BITS-1:0] qq5;
	logic [FRAC_BITS+2:0] t_u2;
	logic [FRAC_BITS+1:0] h3;
	logic [FRAC_BITS+4:0] fden;
	logic [63:0] sum8;
	logic [AREA_W-1:0] far8;
	logic [SCL_W-1:0] sx4, sy4, sz4;
	logic [SUM_W-1:0] s4;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 32'd32768;
			cyl_length_q <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data;
				REG_CYL_LENGTH: cyl_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// [column][row] magnitudes
	always_comb begin
		mag_c[0][0] = mag32(item.m00);
		mag_c[0][1] = mag32(item.m10);
		mag_c[0][2] = mag32(item.m20);
		mag_c[1][0] = mag32(item.m01);
		mag_c[1][1] = mag32(item.m11);
		mag_c[1][2] = mag32(item.m21);
		mag_c[2][0] = mag32(item.m02);
		mag_c[2][1] = mag32(item.m12);
		mag_c[2][2] = mag32(item.m22);
		side_c1 = '0;
		side_c1.rgb = {item.color_b, item.color_g, item.color_r};
	end

	always_comb begin
		sx4 = scl_s3[0][FRAC_BITS +: SCL_W];
		sy4 = scl_s3[1][FRAC_BITS +: SCL_W];
		sz4 = scl_s3[2][FRAC_BITS +: SCL_W];
		s4 = {1'b0, sx4} + {1'b0, sy4};
		side_c4 = side_s3;
		side_c4.sx = sx4;
		side_c4.sy = sy4;
		side_c4.sz = sz4;
		side_c4.s = s4;
		side_c4.sxz = {1'b0, sx4} + {1'b0, sz4};
		side_c4.d = (sx4 > sy4) ? (sx4 - sy4) : (sy4 - sx4);
		side_c4.zero = (sx4 == '0) && (sy4 == '0) && (sz4 == '0);
		side_c4.near = (side_c4.d < NEAR_Q[SCL_W-1:0]) || (s4 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_u1;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c1;
		side_s2 <= side_s1;
		side_s3 <= side_u1;
		side_s4 <= side_c4;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				sq_s1[c][r] <= 64'(mag_c[c][r]) * 64'(mag_c[c][r]);
			end
			len2_s2[c] <= sq_s1[c][0] + sq_s1[c][1] + sq_s1[c][2];
			scl_s3[c] <= 64'(len_u1[c]) * 64'((c == 2) ? cyl_length_q : radius_q);
		end
	end

	clan_isqrt u_len (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .in_side(side_s2), .rad(len2_s2),
		.out_vld(vld_u1), .out_side(side_u1), .root(len_u1)
	);

	// caps: 2*pi*sx*sy
	clan_mulq u_m1 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s4), .in_side(side_s4),
		.a({16'b0, side_s4.sx}), .b({16'b0, side_s4.sy}),
		.out_vld(vld_m1), .out_side(side_m1), .p(p_m1)
	);
	clan_mulq u_m2 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_m1), .in_side(side_m1),
		.a(TWO_PI_Q), .b({1'b0, p_m1}),
		.out_vld(vld_m2), .out_side(side_m2), .p(p_m2)
	);

	// circular area: 2*pi*sx*(sx+sz)
	always_comb begin
		side_m3i = side_m2;
		side_m3i.cap2 = p_m2;
	end
	clan_mulq u_m3 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_m2), .in_side(side_m3i),
		.a({16'b0, side_m3i.sx}), .b({15'b0, side_m3i.sxz}),
		.out_vld(vld_m3), .out_side(side_m3), .p(p_m3)
	);
	clan_mulq u_m4 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_m3), .in_side(side_m3),
		.a(TWO_PI_Q), .b({1'b0, p_m3}),
		.out_vld(vld_m4), .out_side(side_m4), .p(p_m4)
	);

	always_comb begin
		side_m5i = side_m4;
		side_m5i.narea = p_m4;
	end
	clan_mulq u_m5 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_m4), .in_side(side_m5i),
		.a(PI_Q), .b({15'b0, side_m5i.s}),
		.out_vld(vld_m5), .out_side(side_m5), .p(p_m5)
	);

	// axis ratio |sx-sy|/(sx+sy)
	always_comb begin
		side_d1i = side_m5;
		side_d1i.pis = p_m5;
		num_d1 = '0;
		den_d1 = '0;
		num_d1[0] = {side_d1i.d, {FRAC_BITS{1'b0}}};
		den_d1[0] = 63'(side_d1i.s);
	end
	clan_div u_qdiv (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_m5), .in_side(side_d1i),
		.num(num_d1), .den(den_d1),
		.out_vld(vld_d1), .out_side(side_d1), .quot(quot_d1), .sat(sat_d1)
	);

	// equal sums and differences give the all-ones ratio of the bit loop
	assign q5 = ({1'b0, side_d1.d} == side_d1.s) ? {FRAC_BITS{1'b1}}
		: quot_d1[0][FRAC_BITS-1:0];
	assign qq5 = 32'(q5) * 32'(q5);

	always_comb begin
		side_c5 = side_d1;
		side_c5.h = qq5[2*FRAC_BITS-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_d1;
		end
	end
	always_ff @(posedge clk) begin
		side_s5 <= side_c5;
	end

	always_comb begin
		t_u2 = (FRAC_BITS+3)'(FOUR_Q[FRAC_BITS+2:0] - 3 * {3'b0, side_s5.h});
		rad_u2 = '0;
		rad_u2[0] = 64'({t_u2, {FRAC_BITS{1'b0}}});
	end
	clan_isqrt u_rsqrt (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s5), .in_side(side_s5), .rad(rad_u2),
		.out_vld(vld_u2), .out_side(side_u2), .root(root_u2)
	);

	always_comb begin
		h3 = (FRAC_BITS+2)'(3 * {2'b0, side_u2.h});
		fden = TEN_Q[FRAC_BITS+4:0] + (FRAC_BITS+5)'(root_u2[0][FRAC_BITS+1:0]);
		num_d2 = '0;
		den_d2 = '0;
		num_d2[0] = 64'({h3, {FRAC_BITS{1'b0}}});
		den_d2[0] = 63'(fden);
	end
	clan_div u_fdiv (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_u2), .in_side(side_u2),
		.num(num_d2), .den(den_d2),
		.out_vld(vld_d2), .out_side(side_d2), .quot(quot_d2), .sat(sat_d2)
	);

	always_comb begin
		side_c7 = side_d2;
		side_c7.f = ONE_Q[FRAC_BITS:0] + quot_d2[0][FRAC_BITS:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_d2;
		end
	end
	always_ff @(posedge clk) begin
		side_s7 <= side_c7;
	end

	// side: pi*(sx+sy)*f*sz
	clan_mulq u_m6 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s7), .in_side(side_s7),
		.a({1'b0, side_s7.pis}), .b(64'(side_s7.f)),
		.out_vld(vld_m6), .out_side(side_m6), .p(p_m6)
	);
	clan_mulq u_m7 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_m6), .in_side(side_m6),
		.a({1'b0, p_m6}), .b({16'b0, side_m6.sz}),
		.out_vld(vld_m7), .out_side(side_m7), .p(p_m7)
	);

	always_comb begin
		sum8 = {1'b0, side_m7.cap2} + {1'b0, p_m7};
		far8 = (sum8 > {1'b0, AREA_CAP}) ? AREA_CAP : sum8[AREA_W-1:0];
		side_c8 = side_m7;
		side_c8.area = side_m7.near ? side_m7.narea : far8;
	end

	always_comb begin
		side_c9 = side_s8;
		side_c9.azero = (side_s8.area == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s8 <= vld_m7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_d3;
		end
	end

	always_ff @(posedge clk) begin
		side_s8 <= side_c8;
		side_s9 <= side_c9;
		for (int l = 0; l < 3; l++) begin
			num_s9[l] <= 64'(side_s8.rgb[l]) * FOUR_PI_Q;
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			den_d3[l] = side_s9.area;
		end
	end
	clan_div u_cdiv (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s9), .in_side(side_s9),
		.num(num_s9), .den(den_d3),
		.out_vld(vld_d3), .out_side(side_d3), .quot(quot_d3), .sat(sat_d3)
	);

	always_ff @(posedge clk) begin
		if (side_d3.zero) begin
			result_s10 <= result_t'{out_r: side_d3.rgb[0], out_g: side_d3.rgb[1],
				out_b: side_d3.rgb[2], saturated: 1'b0};
		end else if (side_d3.azero) begin
			result_s10 <= result_t'{out_r: '1, out_g: '1, out_b: '1, saturated: 1'b1};
		end else begin
			result_s10 <= result_t'{
				out_r: sat_d3[0] ? 32'hFFFF_FFFF : quot_d3[0],
				out_g: sat_d3[1] ? 32'hFFFF_FFFF : quot_d3[1],
				out_b: sat_d3[2] ? 32'hFFFF_FFFF : quot_d3[2],
				saturated: |sat_d3};
		end
	end

	assign done = vld_s10;
	assign result = result_s10;

	`CLAN_IMPLY(a_latency, start && !busy, ##LAT done)
	`CLAN_IMPLY(a_no_orphan, done, $past(start && !busy, LAT))
	`CLAN_IMPLY(a_area_cap, vld_s9, side_s9.area <= AREA_CAP)
endmodule
`default_nettype wire

### test/testbench.sv
// self-checking testbench of the cylinder light color normalizer
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import clan_pkg::*;

	localparam int LATENCY = 161;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [63:0] CAP62 = 64'd1 << 62;
	localparam logic [63:0] M32 = 64'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	cylinder_light_area_normalize u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// configuration mirror
	logic [63:0] cur_radius;
	logic [63:0] cur_length;

	item_t pending_lights[$];
	result_t expected_colors[$];
	int sender_idle_pct;
	bit hold_sender;
	int error_count;
	int checked_count;
	int sat_count;
	int passthru_count;
	longint cycle_count;

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bitw;
		r = 0;
		bitw = 64'd1 << 62;
		while (bitw > v) bitw >>= 2;
		while (bitw != 0) begin
			if (v >= r + bitw) begin
				v -= r + bitw;
				r = (r >> 1) + bitw;
			end else begin
				r >>= 1;
			end
			bitw >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
		return (p > {64'd0, CAP62}) ? CAP62 : p[63:0];
	endfunction

	function automatic logic [63:0] axis_len(logic [31:0] a, logic [31:0] b,
			logic [31:0] c);
		logic [63:0] x, y, z;
		x = a[31] ? {32'd0, -a} : {32'd0, a};
		y = b[31] ? {32'd0, -b} : {32'd0, b};
		z = c[31] ? {32'd0, -c} : {32'd0, c};
		return root64(x * x + y * y + z * z);
	endfunction

	function automatic result_t normalize_color(item_t it);
		result_t o;
		logic [63:0] sx, sy, sz, d, s, area, q, rem, h, r, f;
		logic [63:0] rgb[3];
		logic [127:0] v;
		rgb[0] = {32'd0, it.color_r};
		rgb[1] = {32'd0, it.color_g};
		rgb[2] = {32'd0, it.color_b};
		sx = (axis_len(it.m00, it.m10, it.m20) * cur_radius) >> FRAC_BITS;
		sy = (axis_len(it.m01, it.m11, it.m21) * cur_radius) >> FRAC_BITS;
		sz = (axis_len(it.m02, it.m12, it.m22) * cur_length) >> FRAC_BITS;
		o.saturated = 1'b0;
		if (sx == 0 && sy == 0 && sz == 0) begin
			o.out_r = it.color_r;
			o.out_g = it.color_g;
			o.out_b = it.color_b;
			return o;
		end
		d = (sx > sy) ? sx - sy : sy - sx;
		s = sx + sy;
		if (d < NEAR_Q || s == 0) begin
			area = qmul(TWO_PI_Q, qmul(sx, sx + sz));
		end else begin
			q = 0;
			rem = d;
			for (int k = 0; k < FRAC_BITS; k++) begin
				rem <<= 1;
				q <<= 1;
				if (rem >= s) begin
					rem -= s;
					q |= 1;
				end
			end
			h = (q * q) >> FRAC_BITS;
			r = root64((4 * ONE_Q - 3 * h) << FRAC_BITS);
			f = ONE_Q + ((3 * h) << FRAC_BITS) / (10 * ONE_Q + r);
			area = qmul(TWO_PI_Q, qmul(sx, sy)) + qmul(qmul(qmul(PI_Q, s), f), sz);
			if (area > CAP62) area = CAP62;
		end
		if (area == 0) begin
			o.out_r = '1;
			o.out_g = '1;
			o.out_b = '1;
			o.saturated = 1'b1;
			return o;
		end
		for (int k = 0; k < 3; k++) begin
			v = ({64'd0, rgb[k]} * {64'd0, FOUR_PI_Q}) / {64'd0, area};
			if (v > {64'd0, M32}) begin
				v = {64'd0, M32};
				o.saturated = 1'b1;
			end
			rgb[k] = v[63:0];
		end
		o.out_r = rgb[0][31:0];
		o.out_g = rgb[1][31:0];
		o.out_b = rgb[2][31:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want,
			checked_count);
		error_count++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy) begin
				expected_colors.push_back(normalize_color(item));
			end
			if ((start && busy) ) begin
				// beat still waiting
			end else if (!hold_sender && pending_lights.size() > 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
				start <= 1'b1;
				item <= pending_lights.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_colors.size() == 0) begin
				$display("unexpected result beat %h", result);
				error_count++;
			end else begin
				result_t want;
				want = expected_colors.pop_front();
				if (result.out_r !== want.out_r) report_mismatch("out_r", result.out_r, want.out_r);
				if (result.out_g !== want.out_g) report_mismatch("out_g", result.out_g, want.out_g);
				if (result.out_b !== want.out_b) report_mismatch("out_b", result.out_b, want.out_b);
				if (result.saturated !== want.saturated)
					report_mismatch("saturated", result.saturated, want.saturated);
				if (want.saturated) sat_count++;
				checked_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(32'h0002_0000);
			2: return -$urandom_range(32'h0002_0000);
			3: return 32'h8000_0000;
			4: return 32'd0;
			default: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
		endcase
	endfunction

	function automatic item_t rand_light();
		item_t it;
		int shape;
		logic [31:0] sc;
		shape = $urandom_range(9);
		it.m00 = rand_entry(); it.m01 = rand_entry(); it.m02 = rand_entry();
		it.m10 = rand_entry(); it.m11 = rand_entry(); it.m12 = rand_entry();
		it.m20 = rand_entry(); it.m21 = rand_entry(); it.m22 = rand_entry();
		if (shape < 3) begin
			// scaled rotation-free matrix, often equal x and y scale
			sc = $urandom_range(32'h0004_0000);
			it = '0;
			it.m00 = sc;
			it.m11 = (shape == 0) ? sc : sc + $urandom_range(8) - 4;
			it.m22 = $urandom_range(32'h0004_0000);
		end else if (shape == 3) begin
			it.m00 = 0; it.m10 = 0; it.m20 = 0;
			it.m01 = 0; it.m11 = 0; it.m21 = 0;
		end
		it.color_r = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h000F_FFFF);
		it.color_g = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h000F_FFFF);
		it.color_b = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h000F_FFFF);
		return it;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_RADIUS) cur_radius = {32'd0, val};
		else cur_length = {32'd0, val};
		@(posedge clk);
	endtask

	task automatic drain();
		wait (pending_lights.size() == 0);
		@(posedge clk);
		while (start || expected_colors.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic directed_lights();
		item_t it;
		it = '0;
		it.color_r = 32'h0001_0000; it.color_g = '1; it.color_b = 0;
		pending_lights.push_back(it); // all scales zero
		it.m00 = 32'h0001_0000; it.m11 = 32'h0001_0000; it.m22 = 32'h0001_0000;
		pending_lights.push_back(it); // circle
		it.m11 = 32'h0002_0000;
		pending_lights.push_back(it); // ellipse
		it.m22 = 0;
		pending_lights.push_back(it); // no length
		it.m00 = 32'h8000_0000; it.m01 = 32'h8000_0000; it.m02 = 32'h8000_0000;
		it.m10 = 32'h7FFF_FFFF; it.m11 = 32'h7FFF_FFFF; it.m12 = 32'h7FFF_FFFF;
		it.m20 = 32'h8000_0000; it.m21 = 32'h8000_0000; it.m22 = 32'h8000_0000;
		pending_lights.push_back(it); // huge area
		it = '0;
		it.m00 = 32'd1; it.m11 = 32'd1; it.color_r = '1; it.color_g = '1; it.color_b = '1;
		pending_lights.push_back(it); // tiny scale: all scales round to zero
		it.m00 = 32'hFFFF_FFFF; it.m11 = 32'h0000_0100;
		pending_lights.push_back(it);
		it.m01 = 32'h0000_0007; it.m11 = 32'h0000_0001; it.m00 = 32'h0000_0001;
		pending_lights.push_back(it); // unequal axes, still within the near-circle bound
		for (int k = 0; k < 12; k++) pending_lights.push_back(rand_light());
	endtask

	initial begin
		logic [31:0] radii[5];
		logic [31:0] lens[5];
		radii = '{32'h0000_8000, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100};
		lens = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'h0003_0000, 32'd1};
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_sender = 0;
		sender_idle_pct = 21;
		error_count = 0;
		checked_count = 0;
		sat_count = 0;
		cycle_count = 0;
		cur_radius = 64'h8000;
		cur_length = 64'h10000;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_lights();
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_RADIUS, radii[ph]);
			write_reg(REG_CYL_LENGTH, lens[ph]);
			sender_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 48 : 0;
			for (int n = 0; n < 340; n++) begin
				pending_lights.push_back(rand_light());
				if (n == 170) begin
					// let the pipe run dry once mid phase
					wait (pending_lights.size() == 0);
					hold_sender = 1;
					@(posedge clk);
					while (start || expected_colors.size() > 0) @(posedge clk);
					hold_sender = 0;
				end
			end
			drain();
		end
		$display("checked %0d results over 5 register settings, %0d saturated",
			checked_count, sat_count);
		if (error_count == 0 && expected_colors.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/clan_pkg.sv
sv/clan_isqrt.sv
sv/clan_div.sv
sv/clan_mulq.sv
sv/cylinder_light_area_normalize.sv
test/testbench.sv
